@@ rtl/histogram_nonadjacent_max_sum_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the histogram non-adjacent maximum sum block
// Concurrent checks clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_NONADJACENT_MAX_SUM_MACROS_SVH
`define HISTOGRAM_NONADJACENT_MAX_SUM_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define HNMS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// condition must never be true outside reset
`define HNMS_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define HNMS_ASSERT(label, prop, msg)
`define HNMS_NEVER(label, cond, msg)
`endif

`endif

@@ rtl/hnms_pkg.sv @@
// ----------------------------------------------------------------------------
// hnms_pkg
// Constants, types and helpers shared by the histogram non-adjacent sum block.
// ----------------------------------------------------------------------------
package hnms_pkg;

   localparam int VALUE_WIDTH = 10;
   localparam int SCORE_BITS  = 22;
   localparam int VALUE_BITS  = 10;
   localparam int MAX_ITEMS   = 4096;

   localparam int BIN_COUNT = 1 << VALUE_BITS;
   localparam longint MAX_TOTAL = longint'(MAX_ITEMS) * longint'(BIN_COUNT - 1);
   localparam int WEIGHT_BITS = $clog2(MAX_TOTAL + 1);
   localparam int COUNT_BITS  = $clog2(MAX_ITEMS + 1);
   localparam int SAT_BITS    = (WEIGHT_BITS > SCORE_BITS) ? WEIGHT_BITS : SCORE_BITS;

   localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
   localparam logic [VALUE_BITS-1:0] LAST_BIN  = VALUE_BITS'(BIN_COUNT - 1);

   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [VALUE_BITS-1:0] bin;
      logic                  add;
      logic                  last;
      logic                  overflow;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [2:0] {
      BACK_CLEAR,
      BACK_LOAD,
      BACK_FLUSH,
      BACK_SCAN,
      BACK_TAIL
   } back_state_type;

   function automatic logic [SCORE_BITS-1:0] saturate(input logic [WEIGHT_BITS-1:0] x);
      logic [SAT_BITS-1:0] wide;
      wide = SAT_BITS'(x);
      if (wide > SAT_BITS'(SCORE_MAX)) begin
         return SCORE_MAX;
      end
      return SCORE_BITS'(wide);
   endfunction

endpackage

@@ rtl/hnms_ram.sv @@
// ----------------------------------------------------------------------------
// hnms_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hnms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the contents before a write at the same edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/hnms_queue.sv @@
// ----------------------------------------------------------------------------
// hnms_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module hnms_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hnms_pkg::entry_type        push_entry,
   input  logic                       pop,
   output hnms_pkg::entry_type        head_entry,
   output hnms_pkg::queue_status_type status
);
   import hnms_pkg::*;

   entry_type                   slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH));

endmodule

@@ rtl/hnms_front.sv @@
// ----------------------------------------------------------------------------
// hnms_front
// Accepts requests, counts the set and marks dropped and final requests.
// ----------------------------------------------------------------------------
module hnms_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [hnms_pkg::VALUE_WIDTH-1:0]     req_value,
   input  logic                                 req_last,
   input  hnms_pkg::queue_status_type           q_status,
   input  hnms_pkg::back_status_type            b_status,
   output logic                                 busy,
   output logic                                 q_push,
   output hnms_pkg::entry_type                  q_entry
);
   import hnms_pkg::*;

   logic [COUNT_BITS-1:0] items_seen_ff, items_seen_in;
   logic                  overflow_ff, overflow_in;
   logic                  accept;
   logic                  room;

   assign busy   = q_status.full || b_status.clearing;
   assign accept = start && !busy;
   assign room   = items_seen_ff < COUNT_BITS'(MAX_ITEMS);

   // drop a request beyond the limit unless it closes the set
   assign q_push           = accept && (room || req_last);
   assign q_entry.bin      = VALUE_BITS'(req_value);
   assign q_entry.add      = room;
   assign q_entry.last     = req_last;
   assign q_entry.overflow = overflow_ff || !room;

   always_comb begin
      items_seen_in = items_seen_ff;
      overflow_in   = overflow_ff;
      if (accept) begin
         if (req_last) begin
            items_seen_in = '0;
            overflow_in   = 1'b0;
         end else if (room) begin
            items_seen_in = items_seen_ff + 1'b1;
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_seen_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         items_seen_ff <= items_seen_in;
         overflow_ff   <= overflow_in;
      end
   end

endmodule

@@ rtl/hnms_back.sv @@
// ----------------------------------------------------------------------------
// hnms_back
// Applies queued requests to the bin memory, then scans and clears the bins.
// ----------------------------------------------------------------------------
`include "histogram_nonadjacent_max_sum_macros.svh"

module hnms_back (
   input  logic                              clock,
   input  logic                              reset,
   input  hnms_pkg::entry_type               q_entry,
   input  hnms_pkg::queue_status_type        q_status,
   output logic                              q_pop,
   output hnms_pkg::back_status_type         b_status,
   output logic                              ram_wr_en,
   output logic [hnms_pkg::VALUE_BITS-1:0]   ram_wr_addr,
   output logic [hnms_pkg::WEIGHT_BITS-1:0]  ram_wr_data,
   output logic [hnms_pkg::VALUE_BITS-1:0]   ram_rd_addr,
   input  logic [hnms_pkg::WEIGHT_BITS-1:0]  ram_rd_data,
   output logic                              rsp_strobe,
   output logic [hnms_pkg::SCORE_BITS-1:0]   rsp_score,
   output logic                              rsp_overflow
);
   import hnms_pkg::*;

   back_state_type         state_ff, state_in;
   logic [VALUE_BITS-1:0]  scan_idx_ff, scan_idx_in;

   logic                   ld_valid_ff, ld_valid_in;
   logic [VALUE_BITS-1:0]  ld_bin_ff, ld_bin_in;
   logic                   fw_valid_ff, fw_valid_in;
   logic [VALUE_BITS-1:0]  fw_bin_ff, fw_bin_in;
   logic [WEIGHT_BITS-1:0] fw_data_ff, fw_data_in;

   logic                   sc_valid_ff, sc_valid_in;
   logic [VALUE_BITS-1:0]  sc_bin_ff, sc_bin_in;
   logic [WEIGHT_BITS-1:0] prev_ff, prev_in;
   logic [WEIGHT_BITS-1:0] prev2_ff, prev2_in;
   logic                   ovf_ff, ovf_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [SCORE_BITS-1:0]  rsp_score_ff, rsp_score_in;
   logic                   rsp_overflow_ff, rsp_overflow_in;

   logic [WEIGHT_BITS-1:0] old_weight;
   logic [WEIGHT_BITS-1:0] new_weight;
   logic [WEIGHT_BITS-1:0] take;
   logic [WEIGHT_BITS-1:0] best;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_CLEAR: begin
            if (scan_idx_ff == LAST_BIN) state_in = BACK_LOAD;
         end
         BACK_LOAD: begin
            if (q_pop && q_entry.last) state_in = BACK_FLUSH;
         end
         BACK_FLUSH: begin
            state_in = BACK_SCAN;
         end
         BACK_SCAN: begin
            if (scan_idx_ff == LAST_BIN) state_in = BACK_TAIL;
         end
         BACK_TAIL: begin
            state_in = BACK_LOAD;
         end
         default: begin
            state_in = BACK_CLEAR;
         end
      endcase
   end

   // datapath: forward the previous write into a back-to-back update
   assign old_weight = (fw_valid_ff && fw_bin_ff == ld_bin_ff) ? fw_data_ff : ram_rd_data;
   assign new_weight = old_weight + WEIGHT_BITS'(ld_bin_ff);
   assign take       = prev2_ff + ram_rd_data;
   assign best       = (take > prev_ff) ? take : prev_ff;

   // outputs and stage controls
   always_comb begin
      q_pop           = (state_ff == BACK_LOAD) && !q_status.empty;
      scan_idx_in     = scan_idx_ff;
      ld_valid_in     = q_pop && q_entry.add;
      ld_bin_in       = q_entry.bin;
      fw_valid_in     = ld_valid_ff;
      fw_bin_in       = ld_bin_ff;
      fw_data_in      = new_weight;
      sc_valid_in     = (state_ff == BACK_SCAN);
      sc_bin_in       = scan_idx_ff;
      prev_in         = prev_ff;
      prev2_in        = prev2_ff;
      ovf_in          = ovf_ff;
      rsp_strobe_in   = (state_ff == BACK_TAIL);
      rsp_score_in    = saturate(best);
      rsp_overflow_in = ovf_ff;
      ram_rd_addr     = (state_ff == BACK_SCAN) ? scan_idx_ff : q_entry.bin;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = scan_idx_ff;
      ram_wr_data     = '0;

      if (state_ff == BACK_CLEAR || state_ff == BACK_SCAN) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
      if (state_ff == BACK_CLEAR) begin
         ram_wr_en = 1'b1;
      end
      if (q_pop && q_entry.last) begin
         ovf_in = q_entry.overflow;
      end
      if (ld_valid_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = ld_bin_ff;
         ram_wr_data = new_weight;
      end
      if (state_ff == BACK_FLUSH) begin
         prev_in  = '0;
         prev2_in = '0;
      end
      // clear each bin as the scan consumes it
      if (sc_valid_ff) begin
         prev_in     = best;
         prev2_in    = prev_ff;
         ram_wr_en   = 1'b1;
         ram_wr_addr = sc_bin_ff;
         ram_wr_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_CLEAR;
         scan_idx_ff   <= '0;
         ld_valid_ff   <= 1'b0;
         fw_valid_ff   <= 1'b0;
         sc_valid_ff   <= 1'b0;
         prev_ff       <= '0;
         prev2_ff      <= '0;
         ovf_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         ld_valid_ff   <= ld_valid_in;
         fw_valid_ff   <= fw_valid_in;
         sc_valid_ff   <= sc_valid_in;
         prev_ff       <= prev_in;
         prev2_ff      <= prev2_in;
         ovf_ff        <= ovf_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ld_bin_ff       <= ld_bin_in;
      fw_bin_ff       <= fw_bin_in;
      fw_data_ff      <= fw_data_in;
      sc_bin_ff       <= sc_bin_in;
      rsp_score_ff    <= rsp_score_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign b_status.clearing = (state_ff == BACK_CLEAR);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_score         = rsp_score_ff;
   assign rsp_overflow      = rsp_overflow_ff;

   `HNMS_NEVER(a_no_write_clash, ld_valid_ff && sc_valid_ff, "load and scan write together")
   `HNMS_ASSERT(a_single_result, rsp_strobe_ff |=> !rsp_strobe_ff, "result strobe repeated")
   `HNMS_ASSERT(a_result_then_load, rsp_strobe_ff |-> state_ff == BACK_LOAD, "result not in load")
   `HNMS_NEVER(a_pop_empty, q_pop && q_status.empty, "queue popped while empty")

endmodule

@@ rtl/histogram_nonadjacent_max_sum.sv @@
// ----------------------------------------------------------------------------
// histogram_nonadjacent_max_sum
// Histogram of a set of values and the best non-adjacent sum over its bins.
// ----------------------------------------------------------------------------
// A request (req_value, req_last) is taken at a rising edge where start is
// high and busy is low. Each request that is not dropped lands in a four-entry
// queue; in its load state the back part drains the queue one request per
// cycle with a read-modify-write of the 1024-entry bin memory, forwarding the
// previous write so that repeats of a value stream through at full rate.
// Requests past the 4096th of a set are dropped (a dropped closing request
// still ends the set) and raise rsp_overflow. After the closing request the
// back part passes a flush state, scans all 1024 bins at one bin per cycle and
// zeroes each bin as it passes. A tail state then registers the result. The
// result is held on rsp_score and rsp_overflow for exactly one cycle with
// rsp_strobe high; the receiver cannot stall it, so capture it then. Requests
// of the next set are taken during the scan until the queue is full, then busy
// rises. After reset a clearing pass over all 1024 bins zeroes the bin memory,
// and busy stays high throughout it.
// ----------------------------------------------------------------------------
module histogram_nonadjacent_max_sum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [hnms_pkg::VALUE_WIDTH-1:0]  req_value,
   input  logic                              req_last,
   output logic                              rsp_strobe,
   output logic [hnms_pkg::SCORE_BITS-1:0]   rsp_score,
   output logic                              rsp_overflow
);
   import hnms_pkg::*;

   queue_status_type       q_status;
   back_status_type        b_status;
   entry_type              push_entry;
   entry_type              head_entry;
   logic                   q_push;
   logic                   q_pop;

   logic                   ram_wr_en;
   logic [VALUE_BITS-1:0]  ram_wr_addr;
   logic [WEIGHT_BITS-1:0] ram_wr_data;
   logic [VALUE_BITS-1:0]  ram_rd_addr;
   logic [WEIGHT_BITS-1:0] ram_rd_data;

   // classify incoming requests: count, drop beyond the limit, mark the end
   hnms_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_value (req_value),
      .req_last  (req_last),
      .q_status  (q_status),
      .b_status  (b_status),
      .busy      (busy),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   // decouple acceptance from the memory work
   hnms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // apply updates, then scan, clear and report
   hnms_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_entry      (head_entry),
      .q_status     (q_status),
      .q_pop        (q_pop),
      .b_status     (b_status),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_score    (rsp_score),
      .rsp_overflow (rsp_overflow)
   );

   // bin weights, one entry per value
   hnms_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (BIN_COUNT)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

@@ test/histogram_nonadjacent_max_sum_tb.sv @@
// ----------------------------------------------------------------------------
// histogram_nonadjacent_max_sum_tb
// Self-checking bench for the histogram non-adjacent maximum sum block. A
// driver presents requests from a pending queue with random hold-offs; a
// monitor keeps its own histogram of each set, scans it when the closing
// request is taken and checks every strobed result against the oldest score
// still owed.
// ----------------------------------------------------------------------------
module histogram_nonadjacent_max_sum_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW          = hnms_pkg::VALUE_WIDTH;
   localparam int SW          = hnms_pkg::SCORE_BITS;
   localparam int BINS        = hnms_pkg::BIN_COUNT;
   localparam int SET_LIMIT   = hnms_pkg::MAX_ITEMS;
   localparam int WEIGHT_W    = 23;
   localparam int GAP_MAX     = 18;
   // closing request to result, plus margin for the flush and queue drain
   localparam int SCAN_CYCLES = 1100;
   localparam int RANDOM_REQS = 580;

   typedef struct {
      logic [VW-1:0] value;
      logic          last;
      int unsigned   gap;
      bit            drain;   // hold this request until no score is owed
   } request_type;

   typedef struct {
      logic [SW-1:0] score;
      logic          overflow;
   } set_score_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic [VW-1:0] req_value = '0;
   logic          req_last = 1'b0;
   logic          rsp_strobe;
   logic [SW-1:0] rsp_score;
   logic          rsp_overflow;

   request_type   request_queue[$];
   set_score_type score_queue[$];

   // predicted histogram and set bookkeeping
   bit [WEIGHT_W-1:0] hist_bins[BINS];
   bit [13:0]         set_count;
   bit                set_dropped;

   int          results_owed = 0;
   int          failures = 0;
   int unsigned hold_off = 0;
   bit          armed = 1'b0;
   int          cycle_count = 0;
   int          cycle_limit = 0;
   int          n_requests = 0;
   int          n_sets = 0;

   histogram_nonadjacent_max_sum dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .req_last     (req_last),
      .rsp_strobe   (rsp_strobe),
      .rsp_score    (rsp_score),
      .rsp_overflow (rsp_overflow)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Queue one request for the driver; a draining request is given a nonzero gap
   // so that the owed count has caught up with the last acceptance.
   task automatic add_request(input logic [VW-1:0] value, input logic last,
                              input int unsigned gap, input bit drain);
      request_type r;
      r.value = value;
      r.last  = last;
      r.gap   = (drain && gap == 0) ? 1 : gap;
      r.drain = drain;
      request_queue.insert(request_queue.size(), r);
      n_requests++;
      if (last) begin
         n_sets++;
      end
   endtask

   // Fold one accepted request into the predicted histogram; on the closing
   // request scan the bins, owe the score and clear for the next set.
   task automatic fold_request(input logic [VW-1:0] value, input logic last);
      bit [WEIGHT_W:0] prev;
      bit [WEIGHT_W:0] prev2;
      bit [WEIGHT_W:0] take;
      bit [WEIGHT_W:0] next_best;
      bit [hnms_pkg::VALUE_BITS-1:0] bin;
      set_score_type s;
      bin = value[hnms_pkg::VALUE_BITS-1:0];
      if (set_count < SET_LIMIT) begin
         hist_bins[bin] += WEIGHT_W'(bin);
         set_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (last) begin
         prev  = '0;
         prev2 = '0;
         for (int i = 0; i < BINS; i++) begin
            take      = prev2 + hist_bins[i];
            next_best = (take > prev) ? take : prev;
            prev2     = prev;
            prev      = next_best;
         end
         s.score    = (prev > hnms_pkg::SCORE_MAX) ? hnms_pkg::SCORE_MAX : SW'(prev);
         s.overflow = set_dropped;
         score_queue.insert(score_queue.size(), s);
         foreach (hist_bins[i]) hist_bins[i] = '0;
         set_count   = '0;
         set_dropped = 1'b0;
      end
   endtask

   // Driver: hold while start is high and busy, otherwise serve the hold-off
   // of the next request, wait out owed scores if it drains, then present it.
   always @(posedge clock) begin : driver
      request_type next_req;
      if (!reset && !(start && busy)) begin
         if (!armed && request_queue.size() != 0) begin
            hold_off = request_queue[0].gap;
            armed    = 1'b1;
         end
         if (request_queue.size() == 0) begin
            start <= 1'b0;
         end else if (hold_off != 0) begin
            hold_off--;
            start <= 1'b0;
         end else if (request_queue[0].drain && results_owed != 0) begin
            start <= 1'b0;
         end else begin
            next_req = request_queue.pop_front();
            req_value <= next_req.value;
            req_last  <= next_req.last;
            start     <= 1'b1;
            armed     = 1'b0;
         end
      end
   end

   // Monitor: check the strobed result first, then fold the request taken at
   // this edge, so a result never meets a score owed in the same cycle.
   always @(posedge clock) begin : monitor
      set_score_type want;
      if (reset) begin
         foreach (hist_bins[i]) hist_bins[i] = '0;
         set_count   = '0;
         set_dropped = 1'b0;
         score_queue.delete();
         results_owed <= 0;
      end else begin
         if (rsp_strobe) begin
            if (score_queue.size() == 0) begin
               $display("%0t: unexpected result, score %0d overflow %0d",
                        $time, rsp_score, rsp_overflow);
               failures++;
            end else begin
               want = score_queue.pop_front();
               if (rsp_score !== want.score) begin
                  $display("%0t: score mismatch, expected %0d actual %0d",
                           $time, want.score, rsp_score);
                  failures++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $display("%0t: overflow mismatch, expected %0d actual %0d",
                           $time, want.overflow, rsp_overflow);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            fold_request(req_value, req_last);
         end
         results_owed <= score_queue.size();
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= cycle_limit) begin
         $display("histogram_nonadjacent_max_sum regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int          random_sent;
      int          set_len;
      int          base;
      bit          quiet;
      bit          clustered;
      bit          drain;
      int unsigned gap;
      logic [VW-1:0] v;

      // Directed: single-element sets at both ends of the value range.
      add_request(10'd0, 1'b1, 0, 1'b0);
      add_request(10'd1023, 1'b1, $urandom_range(0, GAP_MAX), 1'b1);
      // Neighbours exclude each other: {1,2,3} gives 4.
      add_request(10'd1, 1'b0, 0, 1'b0);
      add_request(10'd2, 1'b0, 0, 1'b0);
      add_request(10'd3, 1'b1, $urandom_range(0, GAP_MAX), 1'b0);
      // Repeats back to back stream through the forwarding path.
      add_request(10'd3, 1'b0, 0, 1'b0);
      add_request(10'd3, 1'b0, 0, 1'b0);
      add_request(10'd3, 1'b0, 0, 1'b0);
      add_request(10'd2, 1'b0, 0, 1'b0);
      add_request(10'd2, 1'b0, 0, 1'b0);
      add_request(10'd4, 1'b1, 0, 1'b0);
      // Top bins next to the bottom bins.
      add_request(10'd1023, 1'b0, $urandom_range(0, GAP_MAX), 1'b0);
      add_request(10'd1022, 1'b0, 0, 1'b0);
      add_request(10'd1022, 1'b0, $urandom_range(0, GAP_MAX), 1'b0);
      add_request(10'd0, 1'b0, 0, 1'b0);
      add_request(10'd1, 1'b1, 0, 1'b0);
      // Alternating bit patterns.
      add_request(10'h155, 1'b0, $urandom_range(0, GAP_MAX), 1'b0);
      add_request(10'h2AA, 1'b1, 0, 1'b0);

      // Random sets: mostly clustered values so that neighbours compete.
      random_sent = 0;
      while (random_sent < RANDOM_REQS) begin
         set_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                 : $urandom_range(1, 24);
         quiet     = ($urandom_range(0, 2) == 0);
         clustered = ($urandom_range(0, 4) != 0);
         drain     = ($urandom_range(0, 7) == 0);
         base      = $urandom_range(0, BINS - 1);
         for (int i = 0; i < set_len; i++) begin
            if (clustered) begin
               v = VW'(base + $urandom_range(0, 15));
            end else begin
               v = VW'($urandom_range(0, BINS - 1));
            end
            gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
            add_request(v, i == set_len - 1, gap, drain && i == 0);
         end
         random_sent += set_len;
      end

      cycle_limit = 4 * (n_requests * (GAP_MAX + 2) + (n_sets + 2) * SCAN_CYCLES + 2 * BINS);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every score to arrive.
      @(negedge clock);
      while (request_queue.size() != 0 || start || results_owed != 0) begin
         @(negedge clock);
      end
      // Allow for a stray late result.
      repeat (SCAN_CYCLES) @(negedge clock);

      if (failures == 0 && results_owed == 0) begin
         $display("histogram_nonadjacent_max_sum regression: pass");
      end else begin
         $display("histogram_nonadjacent_max_sum regression: fail");
      end
      $finish;
   end

endmodule
